[sv/kss_pkg.sv]
// ============================================================================
// kss_pkg
// Shared constants, types and helpers for the k-th smallest selector.
// ============================================================================
package kss_pkg;

    // Element store geometry
    localparam int DEPTH   = 64;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = ADDR_W + 1;
    localparam int RANK_W  = 6;

    // Pivot generator
    localparam int                 LFSR_W    = 16;
    localparam logic [LFSR_W-1:0]  LFSR_SEED = 16'hACE1;
    localparam logic [LFSR_W-1:0]  LFSR_TAPS = 16'hB400;

    // Register file: one register per 32-bit word
    localparam int                   PADDR_W   = 3;
    localparam int                   REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_RANK  = '0;

    // Selection sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PICK,
        ST_RD_HI,
        ST_SWAP_A,
        ST_SWAP_B,
        ST_SCAN_RD,
        ST_SCAN_CMP,
        ST_SCAN_SW1,
        ST_SCAN_SW2,
        ST_FIN_WA,
        ST_FIN_WB,
        ST_DONE
    } kss_state_t;

    // One result as it leaves the engine
    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] value;
    } kss_result_t;

    // Smallest all-ones mask that covers v
    function automatic logic [ADDR_W-1:0] cover_mask(input logic [ADDR_W-1:0] v);
        logic [ADDR_W-1:0] m;
        m = v;
        for (int i = 0; i < ADDR_W; i++) begin
            m = m | (m >> 1);
        end
        return m;
    endfunction

    // Galois LFSR step; never settles at zero
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] s);
        logic [LFSR_W-1:0] n;
        n = s >> 1;
        if (s[0])
        begin
            n = n ^ LFSR_TAPS;
        end
        if (n == '0)
        begin
            n = LFSR_SEED;
        end
        return n;
    endfunction

endpackage

[sv/kss_ram.sv]
// ============================================================================
// kss_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module kss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[sv/kss_cfg.sv]
// ============================================================================
// kss_cfg
// APB register file holding the requested rank.
// ============================================================================
module kss_cfg (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [kss_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output logic [kss_pkg::RANK_W-1:0]    rank
);
    import kss_pkg::*;

    logic [RANK_W-1:0]    rank_reg;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_req;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_req  = psel && penable && pwrite && pready;
    assign rank    = rank_reg;

    // Latch rank on a write request to its address
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rank_reg <= '0;
        end
        else if (wr_req && (reg_idx == REG_RANK))
        begin
            rank_reg <= pwdata[RANK_W-1:0];
        end
    end

    // Read mux
    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_RANK: prdata = 32'(rank_reg);
            default:  prdata = '0;
        endcase
    end

endmodule

[sv/kss_engine.sv]
// ============================================================================
// kss_engine
// Loads the element store and runs quickselect over it: Lomuto partition
// passes around an LFSR-drawn pivot, narrowing the window until the pivot
// lands on the requested rank.
// ============================================================================
module kss_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [kss_pkg::DATA_W-1:0] in_value,
    input  logic                              in_last,
    input  logic [kss_pkg::RANK_W-1:0]        rank,
    output logic                              res_valid,
    input  logic                              res_ready,
    output kss_pkg::kss_result_t              res
);
    import kss_pkg::*;

    kss_state_t               state_reg, state_next;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic [ADDR_W-1:0]        lo_reg, lo_next;
    logic [ADDR_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]        j_reg, j_next;
    logic [ADDR_W-1:0]        fill_reg, fill_next;
    logic [ADDR_W-1:0]        pick_reg, pick_next;
    logic [ADDR_W-1:0]        k_reg, k_next;
    logic [LFSR_W-1:0]        lfsr_reg, lfsr_next;
    logic signed [DATA_W-1:0] pivot_reg, pivot_next;
    logic signed [DATA_W-1:0] cur_reg, cur_next;
    kss_result_t              res_reg, res_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [DATA_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [DATA_W-1:0] mem_rdata;

    logic              has_room;
    logic [CNT_W-1:0]  count_new;
    logic [LFSR_W-1:0] lfsr_new;
    logic [ADDR_W-1:0] span_m1;
    logic [ADDR_W-1:0] draw;
    logic [ADDR_W-1:0] offset;

    kss_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Load bookkeeping
    assign has_room  = (count_reg < CNT_W'(DEPTH));
    assign count_new = count_reg + CNT_W'(has_room);

    // Pivot draw folded into [lo, hi] with one compare and subtract
    assign lfsr_new = lfsr_step(lfsr_reg);
    assign span_m1  = hi_reg - lo_reg;
    assign draw     = lfsr_new[ADDR_W-1:0] & cover_mask(span_m1);
    assign offset   = (draw > span_m1) ? (draw - span_m1 - ADDR_W'(1)) : draw;

    // State and working registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            lo_reg    <= '0;
            hi_reg    <= '0;
            lfsr_reg  <= LFSR_SEED;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            lo_reg    <= lo_next;
            hi_reg    <= hi_next;
            lfsr_reg  <= lfsr_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        j_reg     <= j_next;
        fill_reg  <= fill_next;
        pick_reg  <= pick_next;
        k_reg     <= k_next;
        pivot_reg <= pivot_next;
        cur_reg   <= cur_next;
        res_reg   <= res_next;
    end

    // Sequencer: load, partition passes, result hand-off
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        j_next     = j_reg;
        fill_next  = fill_reg;
        pick_next  = pick_reg;
        k_next     = k_reg;
        lfsr_next  = lfsr_reg;
        pivot_next = pivot_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = count_reg[ADDR_W-1:0];
        mem_wdata  = in_value;
        mem_raddr  = j_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // Store the element unless the store is full
                    mem_we     = has_room;
                    count_next = count_new;
                    if (in_last)
                    begin
                        count_next = '0;
                        k_next     = ADDR_W'(rank);
                        lo_next    = '0;
                        hi_next    = ADDR_W'(count_new - CNT_W'(1));
                        if (CNT_W'(rank) < count_new)
                        begin
                            state_next = ST_PICK;
                        end
                        else
                        begin
                            res_next.found = 1'b0;
                            res_next.value = '0;
                            state_next     = ST_DONE;
                        end
                    end
                end
            end

            ST_PICK:
            begin
                // Advance the LFSR and fetch the pivot
                lfsr_next  = lfsr_new;
                pick_next  = lo_reg + offset;
                mem_raddr  = lo_reg + offset;
                state_next = ST_RD_HI;
            end

            ST_RD_HI:
            begin
                pivot_next = mem_rdata;
                mem_raddr  = hi_reg;
                state_next = ST_SWAP_A;
            end

            ST_SWAP_A:
            begin
                // Move the old top entry into the pivot's place
                mem_we     = 1'b1;
                mem_waddr  = pick_reg;
                mem_wdata  = mem_rdata;
                state_next = ST_SWAP_B;
            end

            ST_SWAP_B:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hi_reg;
                mem_wdata  = pivot_reg;
                j_next     = lo_reg;
                fill_next  = lo_reg;
                state_next = ST_SCAN_RD;
            end

            ST_SCAN_RD:
            begin
                if (j_reg == hi_reg)
                begin
                    // Scan done: fetch the entry at the fill point
                    mem_raddr  = fill_reg;
                    state_next = ST_FIN_WA;
                end
                else
                begin
                    mem_raddr  = j_reg;
                    state_next = ST_SCAN_CMP;
                end
            end

            ST_SCAN_CMP:
            begin
                cur_next = mem_rdata;
                if ($signed(mem_rdata) <= pivot_reg)
                begin
                    if (fill_reg == j_reg)
                    begin
                        fill_next  = fill_reg + ADDR_W'(1);
                        j_next     = j_reg + ADDR_W'(1);
                        state_next = ST_SCAN_RD;
                    end
                    else
                    begin
                        mem_raddr  = fill_reg;
                        state_next = ST_SCAN_SW1;
                    end
                end
                else
                begin
                    j_next     = j_reg + ADDR_W'(1);
                    state_next = ST_SCAN_RD;
                end
            end

            ST_SCAN_SW1:
            begin
                // Old fill entry goes to the scan position
                mem_we     = 1'b1;
                mem_waddr  = j_reg;
                mem_wdata  = mem_rdata;
                state_next = ST_SCAN_SW2;
            end

            ST_SCAN_SW2:
            begin
                mem_we     = 1'b1;
                mem_waddr  = fill_reg;
                mem_wdata  = cur_reg;
                fill_next  = fill_reg + ADDR_W'(1);
                j_next     = j_reg + ADDR_W'(1);
                state_next = ST_SCAN_RD;
            end

            ST_FIN_WA:
            begin
                mem_we     = 1'b1;
                mem_waddr  = hi_reg;
                mem_wdata  = mem_rdata;
                state_next = ST_FIN_WB;
            end

            ST_FIN_WB:
            begin
                // Place the pivot and narrow the window toward the rank
                mem_we    = 1'b1;
                mem_waddr = fill_reg;
                mem_wdata = pivot_reg;
                if (fill_reg == k_reg)
                begin
                    res_next.found = 1'b1;
                    res_next.value = pivot_reg;
                    state_next     = ST_DONE;
                end
                else if (fill_reg > k_reg)
                begin
                    hi_next    = fill_reg - ADDR_W'(1);
                    state_next = ST_PICK;
                end
                else
                begin
                    lo_next    = fill_reg + ADDR_W'(1);
                    state_next = ST_PICK;
                end
            end

            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

[sv/kth_smallest_select.sv]
// ============================================================================
// kth_smallest_select
// Order-statistic selector: returns the element of a programmed rank from a
// streamed set of signed values.
// ============================================================================
// Usage:
//   Program the zero-based rank over APB (register 0, byte address 0) while
//   the block is idle. Stream the set on the s_ channel, one signed element
//   per request; s_tlast marks the final element. Up to 64 elements are held;
//   further ones are dropped, but their tlast still closes the set.
//   Loading accepts one element per cycle while the block is idle. After the
//   last element the block runs quickselect in its element RAM: each
//   partition pass reads its window entry by entry and spends extra states on
//   every swap, as the RAM has a single read port and a single write port.
//   The expected total is a few such passes; the worst case is quadratic in
//   the set size. A rank at or beyond the count answers at once.
//   One result per set leaves on the m_ channel: m_tdata holds the value,
//   m_tuser the found flag (value zero when not found).
//   The result sits in an output register; while m_tready is low the block
//   holds it and can already load the next set. Reset empties the set,
//   clears rank to 0 and reseeds the pivot LFSR; no RAM clearing is needed.
// ============================================================================
module kth_smallest_select (
    input  logic                        clk,
    input  logic                        rst_n,
    // Input elements
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [31:0]                 s_tdata,   // [31:0] value
    input  logic                        s_tlast,
    // Results
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [31:0]                 m_tdata,   // [31:0] kth_value
    output logic [0:0]                  m_tuser,   // [0] found
    // Configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kss_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import kss_pkg::*;

    logic [RANK_W-1:0] rank;
    logic              res_valid;
    logic              res_ready;
    kss_result_t       res;

    logic              m_tvalid_reg;
    kss_result_t       out_reg;

    kss_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .rank    (rank)
    );

    kss_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_value  ($signed(s_tdata[DATA_W-1:0])),
        .in_last   (s_tlast),
        .rank      (rank),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Output register takes a new result once the old one is gone
    assign res_ready = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_tvalid_reg <= res_valid;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_reg.value;
    assign m_tuser  = out_reg.found;

endmodule

[bench/kth_smallest_select_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// kth_smallest_select_tb
// Streams signed sets into the selector and checks each result against a
// rank-counting predictor, across several programmed ranks, overfull sets,
// output backpressure and gap-free streaming.
// ============================================================================
module kth_smallest_select_tb;

    import kss_pkg::*;

    localparam int                 WATCHDOG_LIMIT = 40000;
    localparam int                 HOLD_CYCLES    = 1500;
    localparam int                 SETTLE_CYCLES  = 10;
    localparam int                 TAIL_CYCLES    = 20;
    localparam logic [PADDR_W-1:0] RANK_ADDR      = {REG_RANK, 2'b00};
    localparam logic [PADDR_W-1:0] SPARE_ADDR     = {1'b1, 2'b00};

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [DATA_W-1:0]  s_tdata;
    logic               s_tlast;
    logic               m_tvalid;
    logic               m_tready;
    logic [DATA_W-1:0]  m_tdata;
    logic [0:0]         m_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    // Predictor state: held elements, programmed rank, pending results
    logic signed [DATA_W-1:0] held_set[$];
    logic [RANK_W-1:0]        rank_setting;
    kss_result_t              pending_results[$];
    kss_result_t              oldest_result;

    int   error_count;
    int   idle_cycles;
    bit   gaps_enabled;
    bit   hold_request;

    kth_smallest_select dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [31:0] value
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] kth_value
        .m_tuser  (m_tuser),   // [0] found
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Generate the clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t ns: %s: got %08h, expected %08h", $time, what, got, want);
        error_count++;
    endtask

    // Pick the element whose rank window covers k, counting smaller and
    // not-larger elements
    function automatic kss_result_t select_expected(input logic [RANK_W-1:0] k);
        kss_result_t res;
        int          below;
        int          not_above;
        res = '0;
        if (k < held_set.size())
        begin
            foreach (held_set[i])
            begin
                below     = 0;
                not_above = 0;
                foreach (held_set[j])
                begin
                    if (held_set[j] < held_set[i])
                        below++;
                    if (held_set[j] <= held_set[i])
                        not_above++;
                end
                if (below <= k && k < not_above)
                begin
                    res.found = 1'b1;
                    res.value = held_set[i];
                end
            end
        end
        return res;
    endfunction

    // Hold an accepted element; close the set on last
    task automatic absorb_element(input logic signed [DATA_W-1:0] v, input logic is_last);
        if (held_set.size() < DEPTH)
            held_set.push_back(v);
        if (is_last)
        begin
            pending_results.push_back(select_expected(rank_setting));
            held_set.delete();
        end
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_enabled || r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [DATA_W-1:0] rand_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom;
        if (r < 80)
            return $signed($urandom_range(0, 15)) - 8;
        if (r < 90)
        begin
            case ($urandom_range(0, 3))
                0: return VAL_MIN;
                1: return VAL_MAX;
                2: return '0;
                default: return '1;
            endcase
        end
        if (r < 95)
            return VAL_MIN + $urandom_range(0, 3);
        return VAL_MAX - $urandom_range(0, 3);
    endfunction

    // Often sizes around the rank, some small, some filling or overflowing
    function automatic int pick_set_size(input int k);
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range((k > 2) ? k - 2 : 1, k + 3);
        if (r < 75)
            return $urandom_range(1, 16);
        if (r < 90)
            return $urandom_range(1, DEPTH);
        return $urandom_range(DEPTH - 4, DEPTH + 8);
    endfunction

    // Offer one element and wait for the handshake
    task automatic send_element(input logic signed [DATA_W-1:0] v, input logic is_last);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = v;
        s_tlast  = is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_element(v, is_last);
    endtask

    // Drop valid and wait until every pending result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_access(input logic is_write, input logic [PADDR_W-1:0] addr,
                              input logic [31:0] data, output logic [31:0] rdata);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Write the rank and read it back
    task automatic program_rank(input logic [RANK_W-1:0] k);
        logic [31:0] rdata;
        apb_access(1'b1, RANK_ADDR, 32'(k), rdata);
        rank_setting = k;
        apb_access(1'b0, RANK_ADDR, '0, rdata);
        if (rdata !== 32'(rank_setting))
            report_mismatch("rank readback", rdata, 32'(rank_setting));
    endtask

    task automatic send_set(input logic signed [DATA_W-1:0] vals[]);
        foreach (vals[i])
            send_element(vals[i], i == vals.size() - 1);
    endtask

    task automatic run_random_sets(input logic [RANK_W-1:0] k, input int n_items);
        int sent;
        int size;
        sent = 0;
        program_rank(k);
        while (sent < n_items)
        begin
            size = pick_set_size(k);
            for (int i = 0; i < size; i++)
            begin
                send_element(rand_value(), i == size - 1);
                sent++;
            end
        end
        drain_results();
    endtask

    task automatic test_directed_extremes();
        logic [31:0] rdata;
        gaps_enabled = 1'b0;
        // Smallest of mixed extremes with a repeated minimum
        program_rank(0);
        send_set('{VAL_MAX, VAL_MIN, 0, -1, VAL_MIN});
        drain_results();
        // Largest of the same set; a write to the unused slot must not touch rank
        apb_access(1'b1, SPARE_ADDR, 32'h0000_002A, rdata);
        program_rank(4);
        send_set('{VAL_MAX, VAL_MIN, 0, -1, VAL_MIN});
        drain_results();
        // Rank past a single-element set
        send_set('{5});
        drain_results();
        // Duplicates straddling the rank
        program_rank(2);
        send_set('{3, 3, 3, -3});
        drain_results();
        // Highest rank over a short set
        program_rank(RANK_W'(DEPTH - 1));
        send_set('{1, 2, 3});
        drain_results();
    endtask

    task automatic test_rank_boundaries();
        gaps_enabled = 1'b1;
        run_random_sets(0, 300);
        run_random_sets(RANK_W'(DEPTH - 1), 300);
    endtask

    task automatic test_random_ranks();
        gaps_enabled = 1'b1;
        repeat (4)
            run_random_sets(RANK_W'($urandom_range(0, DEPTH - 1)), 250);
    endtask

    task automatic test_output_backpressure();
        gaps_enabled = 1'b0;
        hold_request = 1'b1;
        run_random_sets(RANK_W'($urandom_range(0, 15)), 200);
    endtask

    task automatic test_streaming_no_gaps();
        gaps_enabled = 1'b0;
        run_random_sets(RANK_W'($urandom_range(0, 31)), 150);
    endtask

    // Pace the result side: mostly ready, short stalls, a few long ones
    initial
    begin : rx_pacing
        int run_len;
        int r;
        m_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (hold_request)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 70)
                begin
                    m_tready = 1'b1;
                    run_len  = $urandom_range(1, 40);
                end
                else if (r < 95)
                begin
                    m_tready = 1'b0;
                    run_len  = $urandom_range(1, 4);
                end
                else
                begin
                    m_tready = 1'b0;
                    run_len  = $urandom_range(20, 80);
                end
                repeat (run_len) @(negedge clk);
            end
        end
    end

    // Compare each result with the oldest pending one
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", m_tdata, '0);
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tuser[0] !== oldest_result.found)
                    report_mismatch("found flag", 32'(m_tuser), 32'(oldest_result.found));
                if (m_tdata !== oldest_result.value)
                    report_mismatch("kth value", m_tdata, oldest_result.value);
            end
        end
    end

    // Stop the run if nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable && pready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("kth_smallest_select_tb: errors");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rank_setting = '0;
        error_count  = 0;
        idle_cycles  = 0;
        gaps_enabled = 1'b0;
        hold_request = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_extremes();
        test_rank_boundaries();
        test_random_ranks();
        test_output_backpressure();
        test_streaming_no_gaps();

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results left pending", pending_results.size(), 0);
        if (error_count == 0)
            $display("kth_smallest_select_tb: clean");
        else
            $display("kth_smallest_select_tb: errors");
        $finish;
    end

endmodule
